// File: rtl/core/omw_pkg.sv
// ============================================================================
// omw_pkg: shared types, constants and angle tables for the omni wheel mixer
// Holds the quarter-wave sine table, the sequencer states, the register map
// and the structs passed between the mixer's modules.
// ============================================================================
package omw_pkg;

  // Duty scale: DUTY_MAX is a power of two minus one so that the final scale
  // can be formed as a shift and a subtract.
  localparam int unsigned DutyShift = 8;
  localparam int unsigned DUTY_MAX  = (1 << DutyShift) - 1;
  localparam int unsigned DutyW     = 8;
  localparam int unsigned DriveW    = 9;

  // Shared multiplier geometry.
  localparam int unsigned MulAW = 17;
  localparam int unsigned MulBW = 31;
  localparam int unsigned MulPW = MulAW + MulBW;
  localparam int unsigned ScaleW = MulPW + DutyShift;
  localparam int unsigned RoundBit = 44;

  localparam logic [15:0] SinTab [91] = '{
    16'd0,     16'd572,   16'd1144,  16'd1715,  16'd2286,  16'd2856,  16'd3425,
    16'd3993,  16'd4560,  16'd5126,  16'd5690,  16'd6252,  16'd6813,  16'd7371,
    16'd7927,  16'd8481,  16'd9032,  16'd9580,  16'd10126, 16'd10668, 16'd11207,
    16'd11743, 16'd12275, 16'd12803, 16'd13328, 16'd13848, 16'd14365, 16'd14876,
    16'd15384, 16'd15886, 16'd16384, 16'd16877, 16'd17364, 16'd17847, 16'd18324,
    16'd18795, 16'd19261, 16'd19720, 16'd20174, 16'd20622, 16'd21063, 16'd21498,
    16'd21926, 16'd22348, 16'd22763, 16'd23170, 16'd23571, 16'd23965, 16'd24351,
    16'd24730, 16'd25102, 16'd25466, 16'd25822, 16'd26170, 16'd26510, 16'd26842,
    16'd27166, 16'd27482, 16'd27789, 16'd28088, 16'd28378, 16'd28660, 16'd28932,
    16'd29197, 16'd29452, 16'd29698, 16'd29935, 16'd30163, 16'd30382, 16'd30592,
    16'd30792, 16'd30983, 16'd31164, 16'd31336, 16'd31499, 16'd31651, 16'd31795,
    16'd31928, 16'd32052, 16'd32166, 16'd32270, 16'd32365, 16'd32449, 16'd32524,
    16'd32588, 16'd32643, 16'd32688, 16'd32723, 16'd32748, 16'd32763, 16'd32768
  };

  typedef struct packed {
    logic        neg;
    logic [15:0] mag;
  } trig_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOOK,
    ST_MUL_X,
    ST_MUL_Y,
    ST_MUL_K,
    ST_SUM,
    ST_MUL_D,
    ST_SCALE_D,
    ST_ROUND_D,
    ST_MUL_A,
    ST_SCALE_A,
    ST_ROUND_A,
    ST_SLEW,
    ST_OUT
  } state_e;

  typedef enum logic [1:0] {
    REG_MOUNT = 2'd0,
    REG_GAIN  = 2'd1,
    REG_STEP  = 2'd2,
    REG_MIN   = 2'd3
  } reg_idx_e;

  typedef struct packed {
    logic [8:0]  mount_deg;
    logic [14:0] gain;
    logic [7:0]  step;
    logic [7:0]  min_duty;
  } cfg_t;

  // Packed so that fl_duty lands in the lowest bits of the output word.
  typedef struct packed {
    logic             br_dir;
    logic [DutyW-1:0] br_duty;
    logic             bl_dir;
    logic [DutyW-1:0] bl_duty;
    logic             fr_dir;
    logic [DutyW-1:0] fr_duty;
    logic             fl_dir;
    logic [DutyW-1:0] fl_duty;
  } wheel_out_t;

  // Folds an angle of up to 511 degrees into 0..359.
  function automatic logic [8:0] wrap_deg(logic [8:0] d);
    return (d >= 9'd360) ? (d - 9'd360) : d;
  endfunction

  // Sine of d degrees (d below 360) as sign and magnitude, 32768 = 1.0.
  function automatic trig_t sin_deg(logic [8:0] d);
    logic [8:0] idx;
    trig_t      r;
    if (d <= 9'd90) begin
      idx   = d;
      r.neg = 1'b0;
    end else if (d <= 9'd180) begin
      idx   = 9'd180 - d;
      r.neg = 1'b0;
    end else if (d <= 9'd270) begin
      idx   = d - 9'd180;
      r.neg = 1'b1;
    end else begin
      idx   = 9'd360 - d;
      r.neg = 1'b1;
    end
    r.mag = SinTab[idx[6:0]];
    return r;
  endfunction

  function automatic trig_t cos_deg(logic [8:0] d);
    logic [8:0] s;
    s = (d >= 9'd270) ? (d - 9'd270) : (d + 9'd90);
    return sin_deg(s);
  endfunction

endpackage

// File: rtl/core/omni_wheel_mixer_slew_limit.sv
// ============================================================================
// omni_wheel_mixer_slew_limit: four-wheel omni drive mixer with slew limit
// Turns a speed and heading request into four wheel duties and directions.
// ============================================================================
// Usage:
// A motion request enters on the slave stream (speed_mag, heading_deg) and
// one result per request leaves on the master stream with the duty and the
// direction pin of each wheel. Gain, wheel mount angle, acceleration step
// and minimum duty sit in an APB register file; the user is to change them
// only while no request is in flight, which the block itself leaves unchecked.
// Each request is worked through a sequencer that steps one shared 17 x 31
// bit multiplier through the products it needs: the two trig products, the
// speed-gain product and one scale product per wheel pair. The slave side is
// ready again in the cycle the result appears, so a new request is taken only
// once the last one is through.
// The result waits in an output register. If the receiver stalls, the next
// request is still accepted and worked through, and the sequencer holds in
// its last step until the output register is free.
// Reset clears the sequencer, the output valid and the slew history of all
// four wheels, and loads the register defaults.
// ============================================================================
module omni_wheel_mixer_slew_limit import omw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Slave stream; tdata: speed_mag[15:0], heading_deg[24:16], zero pad.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // Master stream; tdata: fl_duty[7:0], fl_dir[8], fr_duty[16:9], fr_dir[17],
  // bl_duty[25:18], bl_dir[26], br_duty[34:27], br_dir[35], zero pad.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,
  // Configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  state_e state_q, state_d;

  cfg_t   cfg;

  // Request operands.
  logic [15:0] speed_q;
  logic [8:0]  hd_q;

  // Trig lookups for heading and mount angle.
  trig_t sh_q, sw_q, ch_q, cw_q;

  // Products and intermediate values.
  logic signed [31:0]        x_q, y_q;
  logic [MulBW-1:0]          k_q;
  logic [MulAW-1:0]          m15d_q, m15a_q;
  logic                      negd_q, nega_q;
  logic [ScaleW-1:0]         p_q;
  logic signed [DriveW-1:0]  tgt_diag_q, tgt_anti_q;

  logic [MulAW-1:0] mul_a;
  logic [MulBW-1:0] mul_b;
  logic [MulPW-1:0] prod;

  logic signed [32:0] sum_diag, sum_anti;
  logic [ScaleW-1:0]  rnd;
  logic [11:0]        v_raw;
  logic [7:0]         v_sat;
  logic               rnd_neg;
  logic signed [DriveW-1:0] tgt_new;

  wheel_out_t wheel_out;
  logic       slew_en;
  logic       in_fire;
  logic       out_load;
  logic       m_valid_q;
  wheel_out_t m_data_q;

  // Magnitude of a Q2.30 sum rounded half up to Q.15.
  function automatic logic [MulAW-1:0] round_q15(logic signed [32:0] s);
    logic signed [32:0] a;
    logic [31:0]        r;
    a = s[32] ? -s : s;
    r = a[31:0] + 32'd16384;
    return r[31:15];
  endfunction

  omw_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  omw_mul u_mul (
    .clk_i  (clk_i),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  omw_slew u_slew (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .update_i (slew_en),
    .diag_i   (tgt_diag_q),
    .anti_i   (tgt_anti_q),
    .step_i   (cfg.step),
    .min_i    (cfg.min_duty),
    .out_o    (wheel_out)
  );

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid & s_axis_tready;
  assign slew_en       = (state_q == ST_SLEW);
  assign out_load      = (state_q == ST_OUT) && (!m_valid_q || m_axis_tready);

  // Sequencer.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    mul_a   = '0;
    mul_b   = '0;
    unique case (state_q)
      ST_IDLE:    if (in_fire) state_d = ST_LOOK;
      ST_LOOK:    state_d = ST_MUL_X;
      ST_MUL_X: begin
        mul_a   = {1'b0, sh_q.mag};
        mul_b   = {15'd0, sw_q.mag};
        state_d = ST_MUL_Y;
      end
      ST_MUL_Y: begin
        mul_a   = {1'b0, ch_q.mag};
        mul_b   = {15'd0, cw_q.mag};
        state_d = ST_MUL_K;
      end
      ST_MUL_K: begin
        mul_a   = {1'b0, speed_q};
        mul_b   = {16'd0, cfg.gain};
        state_d = ST_SUM;
      end
      ST_SUM:     state_d = ST_MUL_D;
      ST_MUL_D: begin
        mul_a   = m15d_q;
        mul_b   = k_q;
        state_d = ST_SCALE_D;
      end
      ST_SCALE_D: state_d = ST_ROUND_D;
      ST_ROUND_D: state_d = ST_MUL_A;
      ST_MUL_A: begin
        mul_a   = m15a_q;
        mul_b   = k_q;
        state_d = ST_SCALE_A;
      end
      ST_SCALE_A: state_d = ST_ROUND_A;
      ST_ROUND_A: state_d = ST_SLEW;
      ST_SLEW:    state_d = ST_OUT;
      ST_OUT:     if (out_load) state_d = ST_IDLE;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Sum and difference of the trig products, both in Q2.30.
  assign sum_diag = {x_q[31], x_q} + {y_q[31], y_q};
  assign sum_anti = {y_q[31], y_q} - {x_q[31], x_q};

  // Round the scaled product at bit 44, saturate and restore the sign.
  assign rnd     = p_q + (ScaleW'(1) << (RoundBit - 1));
  assign v_raw   = rnd[ScaleW-1:RoundBit];
  assign v_sat   = (v_raw > 12'(DUTY_MAX)) ? 8'(DUTY_MAX) : v_raw[7:0];
  assign rnd_neg = (state_q == ST_ROUND_D) ? negd_q : nega_q;
  assign tgt_new = rnd_neg ? -$signed({1'b0, v_sat}) : $signed({1'b0, v_sat});

  // Datapath registers, loaded by sequencer step.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      speed_q <= s_axis_tdata[15:0];
      hd_q    <= wrap_deg(s_axis_tdata[24:16]);
    end
    unique case (state_q)
      ST_LOOK: begin
        sh_q <= sin_deg(hd_q);
        ch_q <= cos_deg(hd_q);
        sw_q <= sin_deg(wrap_deg(cfg.mount_deg));
        cw_q <= cos_deg(wrap_deg(cfg.mount_deg));
      end
      ST_MUL_Y: begin
        x_q <= (sh_q.neg ^ sw_q.neg) ? -$signed({1'b0, prod[30:0]})
                                     :  $signed({1'b0, prod[30:0]});
      end
      ST_MUL_K: begin
        y_q <= (ch_q.neg ^ cw_q.neg) ? -$signed({1'b0, prod[30:0]})
                                     :  $signed({1'b0, prod[30:0]});
      end
      ST_SUM: begin
        k_q    <= prod[MulBW-1:0];
        m15d_q <= round_q15(sum_diag);
        m15a_q <= round_q15(sum_anti);
        negd_q <= sum_diag[32];
        nega_q <= sum_anti[32];
      end
      // Times DUTY_MAX as a shift and a subtract.
      ST_SCALE_D, ST_SCALE_A: begin
        p_q <= {prod, DutyShift'(0)} - ScaleW'(prod);
      end
      ST_ROUND_D: tgt_diag_q <= tgt_new;
      ST_ROUND_A: tgt_anti_q <= tgt_new;
      default: ;
    endcase
    if (out_load) begin
      m_data_q <= wheel_out;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = {4'd0, m_data_q};

endmodule

// File: rtl/core/omw_cfg.sv
// ============================================================================
// omw_cfg: configuration register file
// Four registers behind an APB-style port, one 32-bit word each.
// ============================================================================
module omw_cfg import omw_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg_o
);

  cfg_t       cfg_q;
  logic       wr_en;
  reg_idx_e   idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;
  assign idx    = reg_idx_e'(paddr[3:2]);
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mount_deg <= 9'd45;
      cfg_q.gain      <= 15'd16384;
      cfg_q.step      <= 8'd10;
      cfg_q.min_duty  <= 8'd0;
    end else if (wr_en) begin
      unique case (idx)
        REG_MOUNT: cfg_q.mount_deg <= pwdata[8:0];
        REG_GAIN:  cfg_q.gain      <= pwdata[14:0];
        REG_STEP:  cfg_q.step      <= pwdata[7:0];
        REG_MIN:   cfg_q.min_duty  <= pwdata[7:0];
        default:   cfg_q           <= cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MOUNT: prdata = {23'd0, cfg_q.mount_deg};
      REG_GAIN:  prdata = {17'd0, cfg_q.gain};
      REG_STEP:  prdata = {24'd0, cfg_q.step};
      REG_MIN:   prdata = {24'd0, cfg_q.min_duty};
      default:   prdata = 32'd0;
    endcase
  end

endmodule

// File: rtl/core/omw_mul.sv
// ============================================================================
// omw_mul: shared unsigned multiplier
// One 17 x 31 bit multiply per cycle with a registered product.
// ============================================================================
module omw_mul import omw_pkg::*; (
  input  logic             clk_i,
  input  logic [MulAW-1:0] a_i,
  input  logic [MulBW-1:0] b_i,
  output logic [MulPW-1:0] prod_o
);

  logic [MulPW-1:0] prod_q;

  always_ff @(posedge clk_i) begin
    prod_q <= MulPW'(a_i) * MulPW'(b_i);
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/core/omw_slew.sv
// ============================================================================
// omw_slew: per-wheel slew limiter and drive split
// Holds the last limited value of each wheel and forms duty and direction.
// ============================================================================
module omw_slew import omw_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     update_i,
  input  logic signed [DriveW-1:0] diag_i,
  input  logic signed [DriveW-1:0] anti_i,
  input  logic [7:0]               step_i,
  input  logic [7:0]               min_i,
  output wheel_out_t               out_o
);

  // Wheel order: front left, front right, back left, back right.
  logic signed [DriveW-1:0] drive_q [4];
  logic signed [DriveW-1:0] drive_d [4];
  logic signed [DriveW-1:0] tgt     [4];

  function automatic logic [7:0] mag8(logic signed [DriveW-1:0] v);
    logic signed [DriveW-1:0] a;
    a = v[DriveW-1] ? -v : v;
    return a[7:0];
  endfunction

  function automatic logic signed [DriveW-1:0] slew_fn(
    logic signed [DriveW-1:0] t,
    logic signed [DriveW-1:0] p,
    logic [7:0]               st
  );
    logic [8:0]               lim;
    logic signed [DriveW:0]   moved;
    lim = {1'b0, mag8(p)} + {1'b0, st};
    if ({1'b0, mag8(t)} < lim) begin
      return t;
    end
    if (t > p) begin
      moved = {p[DriveW-1], p} + $signed({2'b00, st});
    end else begin
      moved = {p[DriveW-1], p} - $signed({2'b00, st});
    end
    return moved[DriveW-1:0];
  endfunction

  function automatic logic [DutyW-1:0] duty_fn(logic signed [DriveW-1:0] v,
                                               logic [7:0] min_duty);
    logic [7:0] m;
    m = mag8(v);
    return (m > min_duty) ? DutyW'(m) : '0;
  endfunction

  assign tgt[0] = diag_i;
  assign tgt[1] = anti_i;
  assign tgt[2] = anti_i;
  assign tgt[3] = diag_i;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      drive_d[i] = slew_fn(tgt[i], drive_q[i], step_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) begin
        drive_q[i] <= '0;
      end
    end else if (update_i) begin
      for (int i = 0; i < 4; i++) begin
        drive_q[i] <= drive_d[i];
      end
    end
  end

  // Left pins are high for a positive value, right pins low.
  always_comb begin
    out_o.fl_duty = duty_fn(drive_q[0], min_i);
    out_o.fl_dir  = (drive_q[0] > 0);
    out_o.fr_duty = duty_fn(drive_q[1], min_i);
    out_o.fr_dir  = !(drive_q[1] > 0);
    out_o.bl_duty = duty_fn(drive_q[2], min_i);
    out_o.bl_dir  = (drive_q[2] > 0);
    out_o.br_duty = duty_fn(drive_q[3], min_i);
    out_o.br_dir  = !(drive_q[3] > 0);
  end

endmodule

// File: rtl/core/omw_checker.sv
// ============================================================================
// omw_checker: port-level checks for the omni wheel mixer
// Watches the streams of the top level and is bound to it below.
// ============================================================================
module omw_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [39:0] m_axis_tdata
);

  // A stalled result stays valid.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("result dropped while stalled");

  // A stalled result keeps its payload.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // The block works on one request at a time.
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready ##1 !s_axis_tready)
    else $error("request taken while busy");

  // A new result appears only as the sequencer returns to idle.
  a_new_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result issued while busy");

  // Diagonal wheels share a value; right pins mirror left pins.
  a_mirror: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[7:0] == m_axis_tdata[34:27]) &&
                      (m_axis_tdata[8] != m_axis_tdata[35]) &&
                      (m_axis_tdata[16:9] == m_axis_tdata[25:18]) &&
                      (m_axis_tdata[17] != m_axis_tdata[26]))
    else $error("wheel pairs disagree");

endmodule

bind omni_wheel_mixer_slew_limit omw_checker u_omw_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// File: tb/sv/omni_wheel_mixer_slew_limit_tb.sv
`timescale 1ns / 100ps
// ============================================================================
// omni_wheel_mixer_slew_limit_tb: self-checking bench for the omni wheel mixer
// Sends motion requests (speed, heading) on the slave stream and checks every
// wheel result against a golden value (typed rows) or an in-bench predictor
// of the mixing, rounding, saturation and per-wheel slew limit. Registers are
// written over APB between phases and read back. A short directed table comes
// first, then phases of random commands under random idling on both streams.
// ============================================================================
module omni_wheel_mixer_slew_limit_tb;
  import omw_pkg::*;

  localparam int unsigned DutyFull    = 255;
  localparam int unsigned HoldCycles  = 60;
  localparam int unsigned StallLimit  = 2000;
  localparam int unsigned PhaseCnt    = 8;
  localparam int unsigned PhaseReqs   = 116;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned MaxReports  = 10;

  // Quarter-wave table, round(32768 * sin(d deg)) for d = 0..90.
  localparam int SineQ15 [91] = '{
    0, 572, 1144, 1715, 2286, 2856, 3425, 3993, 4560, 5126,
    5690, 6252, 6813, 7371, 7927, 8481, 9032, 9580, 10126, 10668,
    11207, 11743, 12275, 12803, 13328, 13848, 14365, 14876, 15384, 15886,
    16384, 16877, 17364, 17847, 18324, 18795, 19261, 19720, 20174, 20622,
    21063, 21498, 21926, 22348, 22763, 23170, 23571, 23965, 24351, 24730,
    25102, 25466, 25822, 26170, 26510, 26842, 27166, 27482, 27789, 28088,
    28378, 28660, 28932, 29197, 29452, 29698, 29935, 30163, 30382, 30592,
    30792, 30983, 31164, 31336, 31499, 31651, 31795, 31928, 32052, 32166,
    32270, 32365, 32449, 32524, 32588, 32643, 32688, 32723, 32748, 32763,
    32768
  };

  // All wheels stopped: left pins read 0 and right pins read 1 at zero.
  localparam wheel_out_t GoldIdle  = '{1'b1, 8'd0, 1'b0, 8'd0, 1'b1, 8'd0, 1'b0, 8'd0};
  // First full-speed forward request after reset: every wheel creeps up by
  // the default step of 10, all moving forward.
  localparam wheel_out_t GoldCreep = '{1'b0, 8'd10, 1'b1, 8'd10, 1'b0, 8'd10, 1'b1, 8'd10};

  typedef enum logic { ROW_REQ, ROW_CFG } row_kind_e;

  typedef struct packed {
    row_kind_e   kind;
    reg_idx_e    reg_sel;
    logic [15:0] value;    // speed of a request, or the value of a register write
    logic [8:0]  heading;
    logic        typed;    // golden holds the expected result
    wheel_out_t  golden;
  } dir_row_t;

  // Directed table. Register writes wait until the mixer is idle.
  localparam dir_row_t DirTab [30] = '{
    '{ROW_REQ, REG_MOUNT, 16'd0,     9'd0,   1'b1, GoldIdle},   // stopped after reset
    '{ROW_REQ, REG_MOUNT, 16'd32768, 9'd0,   1'b1, GoldCreep},  // slew from rest
    '{ROW_REQ, REG_MOUNT, 16'd32768, 9'd0,   1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd32768, 9'd90,  1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd32768, 9'd180, 1'b0, GoldIdle},   // reversal
    '{ROW_REQ, REG_MOUNT, 16'd32768, 9'd270, 1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd32768, 9'd359, 1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd32768, 9'd360, 1'b0, GoldIdle},   // heading wraps
    '{ROW_REQ, REG_MOUNT, 16'd65535, 9'd511, 1'b0, GoldIdle},   // over full speed
    '{ROW_REQ, REG_MOUNT, 16'd65535, 9'd45,  1'b0, GoldIdle},
    '{ROW_CFG, REG_STEP,  16'd255,   9'd0,   1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd65535, 9'd45,  1'b0, GoldIdle},   // saturates
    '{ROW_REQ, REG_MOUNT, 16'd0,     9'd0,   1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd32768, 9'd135, 1'b0, GoldIdle},
    '{ROW_CFG, REG_STEP,  16'd0,     9'd0,   1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd65535, 9'd225, 1'b0, GoldIdle},   // zero step holds
    '{ROW_REQ, REG_MOUNT, 16'd8000,  9'd225, 1'b0, GoldIdle},   // falling is free
    '{ROW_CFG, REG_STEP,  16'd255,   9'd0,   1'b0, GoldIdle},
    '{ROW_CFG, REG_GAIN,  16'd32767, 9'd0,   1'b0, GoldIdle},
    '{ROW_CFG, REG_MOUNT, 16'd0,     9'd0,   1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd65535, 9'd0,   1'b0, GoldIdle},   // largest product
    '{ROW_CFG, REG_MIN,   16'd100,   9'd0,   1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd6000,  9'd20,  1'b0, GoldIdle},   // below minimum
    '{ROW_CFG, REG_MIN,   16'd255,   9'd0,   1'b0, GoldIdle},
    '{ROW_REQ, REG_MOUNT, 16'd32768, 9'd300, 1'b0, GoldIdle},
    '{ROW_CFG, REG_GAIN,  16'd0,     9'd0,   1'b0, GoldIdle},
    '{ROW_CFG, REG_STEP,  16'd10,    9'd0,   1'b0, GoldIdle},
    '{ROW_CFG, REG_MIN,   16'd0,     9'd0,   1'b0, GoldIdle},
    '{ROW_CFG, REG_MOUNT, 16'd511,   9'd0,   1'b0, GoldIdle},   // mount angle wraps
    '{ROW_REQ, REG_MOUNT, 16'd12345, 9'd200, 1'b1, GoldIdle}    // zero gain stops all
  };

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // speed_mag[15:0], heading_deg[24:16], zero pad
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [39:0] m_axis_tdata;   // fl_duty, fl_dir, fr_duty, fr_dir, bl_duty, bl_dir,
                               // br_duty, br_dir from bit 0 up, zero pad
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  // Shadow of the register file and of the slew history (fl, fr, bl, br).
  logic [8:0]  mount_cfg;
  logic [14:0] gain_cfg;
  logic [7:0]  step_cfg;
  logic [7:0]  min_cfg;
  int          wheel_hist [4];

  wheel_out_t  pending_wheels [$];
  int          err_cnt;
  int          quiet_cycles;
  bit          idle_on;
  bit          hold_off_req;
  string       wheel_names [4] = '{"fl", "fr", "bl", "br"};

  omni_wheel_mixer_slew_limit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Sine of d degrees, d in 0..359, with 32768 standing for 1.0.
  function automatic int sine_deg(int d);
    if (d <= 90) return SineQ15[d];
    else if (d <= 180) return SineQ15[180 - d];
    else if (d <= 270) return -SineQ15[d - 180];
    else return -SineQ15[360 - d];
  endfunction

  // Wheel target from a Q2.30 trig sum: round to Q.15, scale by speed, gain
  // and full duty, round at bit 44, saturate and put the sign back.
  function automatic int wheel_target(longint sum, logic [15:0] spd);
    longint unsigned mag, m15, prod, v;
    mag  = (sum < 0) ? -sum : sum;
    m15  = (mag + 64'd16384) >> 15;
    prod = m15 * spd * gain_cfg * 64'd255;
    v    = (prod + (64'd1 << 43)) >> 44;
    if (v > DutyFull) v = DutyFull;
    return (sum < 0) ? -int'(v) : int'(v);
  endfunction

  // Predicts the result of one request and advances the slew history.
  function automatic wheel_out_t mix_wheels(logic [15:0] spd, logic [8:0] hdg);
    int          hd, wd, at, ap, mag;
    int          tgt [4];
    longint      x, y;
    logic [35:0] bits;
    hd = hdg % 360;
    wd = mount_cfg % 360;
    x  = longint'(sine_deg(hd)) * sine_deg(wd);
    y  = longint'(sine_deg((hd + 90) % 360)) * sine_deg((wd + 90) % 360);
    tgt[0] = wheel_target(x + y, spd);
    tgt[1] = wheel_target(y - x, spd);
    tgt[2] = tgt[1];
    tgt[3] = tgt[0];
    for (int i = 0; i < 4; i++) begin
      at = (tgt[i] < 0) ? -tgt[i] : tgt[i];
      ap = (wheel_hist[i] < 0) ? -wheel_hist[i] : wheel_hist[i];
      // A rise in magnitude of a full step or more is cut to one step.
      if (at - ap >= int'(step_cfg)) begin
        wheel_hist[i] = (tgt[i] > wheel_hist[i]) ? wheel_hist[i] + step_cfg
                                                 : wheel_hist[i] - step_cfg;
      end else begin
        wheel_hist[i] = tgt[i];
      end
      mag = (wheel_hist[i] < 0) ? -wheel_hist[i] : wheel_hist[i];
      bits[9*i +: 8] = (mag > min_cfg) ? mag[7:0] : 8'd0;
      // Right-side wheels (fr, br) are mounted mirrored, so their pin inverts.
      bits[9*i + 8]  = (i == 1 || i == 3) ? (wheel_hist[i] <= 0) : (wheel_hist[i] > 0);
    end
    return wheel_out_t'(bits);
  endfunction

  task automatic note_mismatch(input string what, input int unsigned want,
                               input int unsigned got);
    err_cnt++;
    if (err_cnt <= MaxReports) begin
      $display("[%0t] mismatch in %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Offers one request and waits for it to be taken; the prediction is made
  // at acceptance. Valid stays high into the next request unless a gap is
  // inserted, so it is never lowered and raised in the same step.
  task automatic send_req(input logic [15:0] spd, input logic [8:0] hdg,
                          input logic typed, input wheel_out_t golden);
    wheel_out_t w;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {7'd0, hdg, spd};
    do @(posedge clk_i); while (!s_axis_tready);
    w = mix_wheels(spd, hdg);
    pending_wheels.push_back(typed ? golden : w);
  endtask

  // Stops offering and waits until every expected result has come out.
  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_wheels.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write followed by a read-back of the same register.
  task automatic reg_write(input reg_idx_e sel, input logic [31:0] val);
    logic [31:0] want;
    case (sel)
      REG_MOUNT: begin mount_cfg = val[8:0];  want = {23'd0, val[8:0]};  end
      REG_GAIN:  begin gain_cfg  = val[14:0]; want = {17'd0, val[14:0]}; end
      REG_STEP:  begin step_cfg  = val[7:0];  want = {24'd0, val[7:0]};  end
      default:   begin min_cfg   = val[7:0];  want = {24'd0, val[7:0]};  end
    endcase
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {sel, 2'b00};
    pwdata  <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata !== want) note_mismatch("register read-back", want, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Result checker: each accepted result is compared field by field with the
  // oldest expectation.
  always @(posedge clk_i) begin : result_check
    logic [35:0] want, got;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[35:0];
      if (pending_wheels.size() == 0) begin
        note_mismatch("result with no request pending", 0, got[31:0]);
      end else begin
        want = pending_wheels.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (got[9*i +: 8] !== want[9*i +: 8])
            note_mismatch({wheel_names[i], "_duty"}, want[9*i +: 8], got[9*i +: 8]);
          if (got[9*i + 8] !== want[9*i + 8])
            note_mismatch({wheel_names[i], "_dir"}, want[9*i + 8], got[9*i + 8]);
        end
      end
    end
  end

  // Receiver: random ready bursts, plus long hold-offs on request so that
  // the output register and the sequencer fill and the slave side stalls.
  initial begin
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        m_axis_tready <= 1'b0;
        repeat (HoldCycles) @(posedge clk_i);
        hold_off_req   = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk_i);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Watchdog: ends the run when nothing moves on any port for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= StallLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin : stimulus
    int          n;
    int          reps;
    logic [15:0] spd;
    logic [8:0]  hdg;
    dir_row_t    row;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    mount_cfg     = 9'd45;
    gain_cfg      = 15'd16384;
    step_cfg      = 8'd10;
    min_cfg       = 8'd0;
    wheel_hist    = '{0, 0, 0, 0};
    err_cnt       = 0;
    quiet_cycles  = 0;
    idle_on       = 1'b1;
    hold_off_req  = 1'b0;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed table: extremes, wrap-around, saturation, slew and minimum duty.
    foreach (DirTab[r]) begin
      row = DirTab[r];
      if (row.kind == ROW_CFG) begin
        wait_idle();
        reg_write(row.reg_sel, {16'd0, row.value});
      end else begin
        send_req(row.value, row.heading, row.typed, row.golden);
      end
    end

    // Random phases, each under its own register setting. The first three are
    // fixed, mostly at register extremes; the last phase runs without idling.
    for (int phase = 0; phase < PhaseCnt; phase++) begin
      wait_idle();
      case (phase)
        0: begin
          reg_write(REG_MOUNT, 32'd0);
          reg_write(REG_GAIN,  32'd32767);
          reg_write(REG_STEP,  32'd255);
          reg_write(REG_MIN,   32'd0);
        end
        1: begin
          reg_write(REG_MOUNT, 32'd359);
          reg_write(REG_GAIN,  32'd16384);
          reg_write(REG_STEP,  32'd1);
          reg_write(REG_MIN,   32'd30);
        end
        2: begin
          reg_write(REG_MOUNT, 32'd511);
          reg_write(REG_GAIN,  32'd20000);
          reg_write(REG_STEP,  32'd0);
          reg_write(REG_MIN,   32'd255);
        end
        default: begin
          reg_write(REG_MOUNT, $urandom_range(0, 511));
          reg_write(REG_GAIN,  $urandom_range(0, 32767));
          reg_write(REG_STEP,  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 40));
          reg_write(REG_MIN,   ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                                                           : $urandom_range(0, 60));
        end
      endcase
      if (phase == PhaseCnt - 1) idle_on = 1'b0;

      n = 0;
      while (n < PhaseReqs) begin
        // Mid-way through the second phase the receiver stops for a while
        // and the sender keeps offering requests behind it.
        if (phase == 1 && n >= 40 && n < 48) hold_off_req = 1'b1;
        case ($urandom_range(0, 7))
          0:       spd = 16'd0;
          1:       spd = 16'd32768;
          2:       spd = $urandom_range(32769, 65535);
          default: spd = $urandom_range(0, 32768);
        endcase
        hdg = ($urandom_range(0, 7) == 0) ? $urandom_range(360, 511)
                                          : $urandom_range(0, 359);
        // A command is often held for a few requests so the slew can settle.
        reps = $urandom_range(1, 8);
        for (int k = 0; k < reps && n < PhaseReqs; k++) begin
          send_req(spd, hdg, 1'b0, GoldIdle);
          n++;
        end
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (err_cnt == 0 && pending_wheels.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/core/omw_pkg.sv
rtl/core/omw_cfg.sv
rtl/core/omw_mul.sv
rtl/core/omw_slew.sv
rtl/core/omni_wheel_mixer_slew_limit.sv
rtl/core/omw_checker.sv
tb/sv/omni_wheel_mixer_slew_limit_tb.sv
